@@ sv/ntst_pkg.sv @@
package ntst_pkg;

    localparam int THETA_FRAC_BITS = 16;
    localparam int LANES           = 5;

    localparam int TW      = 48;
    localparam int A1W     = 32;
    localparam int A1_FRAC = 24;
    localparam int CW      = 32;
    localparam int OW      = 32;

    localparam int HALF  = A1W / 2;
    localparam int PLW   = TW + HALF;
    localparam int SUMW  = TW + A1W;
    localparam int SW    = SUMW - A1_FRAC;
    localparam int SLO   = CW;
    localparam int SHI   = SW - SLO;
    localparam int UMW   = CW + 1;
    localparam int VMW   = CW;
    localparam int SSW   = 2 * SW;
    localparam int USW   = UMW + SW;
    localparam int PAW   = USW + THETA_FRAC_BITS;
    localparam int SSCH  = 4;
    localparam int SSCW  = SSW / SSCH;
    localparam int VPW   = VMW + SSCW;
    localparam int PBW   = VMW + SSW;
    localparam int DW    = PBW + 2;
    localparam int RTW   = DW / 2;
    localparam int SREMW = RTW + 3;
    localparam int NMW   = SW;
    localparam int NSH   = 28;
    localparam int QW    = 32;
    localparam int NLOW  = QW - NSH;
    localparam int NHW   = NMW - NLOW;
    localparam int DREMW = RTW + 1;

    localparam int ITW    = LANES * TW;
    localparam int OTW    = ((LANES * OW + LANES + 7) / 8) * 8;
    localparam int CFG_IW = 3;
    localparam int CFG_DW = 2 * CW;

    localparam logic [CFG_IW-1:0] REG_A1     = 3'd0;
    localparam logic [CFG_IW-1:0] REG_TAJIMA = 3'd1;
    localparam logic [CFG_IW-1:0] REG_FULI_D = 3'd2;
    localparam logic [CFG_IW-1:0] REG_FULI_F = 3'd3;
    localparam logic [CFG_IW-1:0] REG_FAYWU  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_ZENG   = 3'd5;

    localparam int LANE_TAJIMA = 0;
    localparam int LANE_FULI_D = 1;
    localparam int LANE_FULI_F = 2;
    localparam int LANE_FAYWU  = 3;
    localparam int LANE_ZENG   = 4;

    typedef struct packed {
        logic [LANES-1:0]          nneg;
        logic [LANES-1:0][NMW-1:0] nmag;
        logic [LANES-1:0]          bad;
        logic                      szero;
    } t_side;

endpackage

@@ sv/neutrality_test_statistics_unit.sv @@
// Channel   Dir  Width  Fields (lowest bit up)
// s_axis    in   240    theta_w, theta_pi, theta_fl, theta_h, theta_l (48 each)
// m_axis    out  168    tajima_d, fuli_d, fuli_f, faywu_h, zeng_e (32 each),
//                       invalid_mask (5), zero pad (3)
// cfg       in   64     index 0..5: harmonic_a1, then the five coefficient pairs
//
// One item per cycle while the skid register is empty.
// Latency is set by the 73 one-bit square-root stages and the 32 one-bit
// division stages that follow them, one set per statistic.
// Reset (synchronous, active low) clears the valid bits, the output stage and
// the configuration registers.
// A stalled output fills a one-item skid register; while it is full the
// whole pipeline holds and s_axis_tready is low.
module neutrality_test_statistics_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [ntst_pkg::CFG_IW-1:0]     i_cfg_index,
    input  logic [ntst_pkg::CFG_DW-1:0]     i_cfg_wdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // theta_w, theta_pi, theta_fl, theta_h, theta_l
    input  logic [ntst_pkg::ITW-1:0]        s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // tajima_d, fuli_d, fuli_f, faywu_h, zeng_e, invalid_mask, pad
    output logic [ntst_pkg::OTW-1:0]        m_axis_tdata
);

    localparam int NL    = ntst_pkg::LANES;
    localparam int TW    = ntst_pkg::TW;
    localparam int CW    = ntst_pkg::CW;
    localparam int SW    = ntst_pkg::SW;
    localparam int SLO   = ntst_pkg::SLO;
    localparam int SHI   = ntst_pkg::SHI;
    localparam int UMW   = ntst_pkg::UMW;
    localparam int VMW   = ntst_pkg::VMW;
    localparam int NMW   = ntst_pkg::NMW;
    localparam int DW    = ntst_pkg::DW;
    localparam int RTW   = ntst_pkg::RTW;
    localparam int SREMW = ntst_pkg::SREMW;
    localparam int DREMW = ntst_pkg::DREMW;
    localparam int QW    = ntst_pkg::QW;
    localparam int OW    = ntst_pkg::OW;

    logic                       w_ce;
    logic [ntst_pkg::A1W-1:0]   r_a1;
    logic [2*CW-1:0]            r_pair [NL];
    logic signed [UMW-1:0]      w_u [NL];
    logic signed [VMW-1:0]      w_v [NL];
    logic [UMW-1:0]             r_umag [NL];
    logic [VMW-1:0]             r_vmag [NL];
    logic [NL-1:0]              r_uneg;
    logic [NL-1:0]              r_vneg;

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1 <= '0;
            for (int k = 0; k < NL; k++) r_pair[k] <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                ntst_pkg::REG_A1:     r_a1 <= i_cfg_wdata[ntst_pkg::A1W-1:0];
                ntst_pkg::REG_TAJIMA: r_pair[ntst_pkg::LANE_TAJIMA] <= i_cfg_wdata;
                ntst_pkg::REG_FULI_D: r_pair[ntst_pkg::LANE_FULI_D] <= i_cfg_wdata;
                ntst_pkg::REG_FULI_F: r_pair[ntst_pkg::LANE_FULI_F] <= i_cfg_wdata;
                ntst_pkg::REG_FAYWU:  r_pair[ntst_pkg::LANE_FAYWU]  <= i_cfg_wdata;
                ntst_pkg::REG_ZENG:   r_pair[ntst_pkg::LANE_ZENG]   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            w_u[k] = UMW'($signed(r_pair[k][2*CW-1:CW]));
            w_v[k] = $signed(r_pair[k][CW-1:0]);
        end
        w_u[ntst_pkg::LANE_TAJIMA] =
            UMW'($signed(r_pair[ntst_pkg::LANE_TAJIMA][2*CW-1:CW])) -
            UMW'($signed(r_pair[ntst_pkg::LANE_TAJIMA][CW-1:0]));
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < NL; k++) begin
            r_uneg[k] <= w_u[k][UMW-1];
            r_vneg[k] <= w_v[k][VMW-1];
            r_umag[k] <= w_u[k][UMW-1] ? UMW'(-w_u[k]) : UMW'(w_u[k]);
            r_vmag[k] <= w_v[k][VMW-1] ? VMW'(-w_v[k]) : VMW'(w_v[k]);
        end
    end

    // stage 1: a1 partial products
    logic                      r1_vld;
    logic [ntst_pkg::PLW-1:0]  r1_plo_w, r1_phi_w, r1_plo_l, r1_phi_l;
    logic [TW-1:0]             r1_tw, r1_tpi, r1_tfl, r1_th, r1_tl;

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r1_tw  <= s_axis_tdata[0*TW +: TW];
            r1_tpi <= s_axis_tdata[1*TW +: TW];
            r1_tfl <= s_axis_tdata[2*TW +: TW];
            r1_th  <= s_axis_tdata[3*TW +: TW];
            r1_tl  <= s_axis_tdata[4*TW +: TW];
            r1_plo_w <= ntst_pkg::PLW'(s_axis_tdata[0*TW +: TW]) *
                        ntst_pkg::PLW'(r_a1[ntst_pkg::HALF-1:0]);
            r1_phi_w <= ntst_pkg::PLW'(s_axis_tdata[0*TW +: TW]) *
                        ntst_pkg::PLW'(r_a1[ntst_pkg::A1W-1:ntst_pkg::HALF]);
            r1_plo_l <= ntst_pkg::PLW'(s_axis_tdata[2*TW +: TW]) *
                        ntst_pkg::PLW'(r_a1[ntst_pkg::HALF-1:0]);
            r1_phi_l <= ntst_pkg::PLW'(s_axis_tdata[2*TW +: TW]) *
                        ntst_pkg::PLW'(r_a1[ntst_pkg::A1W-1:ntst_pkg::HALF]);
        end
    end

    // stage 2: S and L
    logic                       r2_vld;
    logic [SW-1:0]              r2_s, r2_l;
    logic [TW-1:0]              r2_tw, r2_tpi, r2_tfl, r2_th, r2_tl;
    logic [ntst_pkg::SUMW-1:0]  w_sum_w, w_sum_l;

    assign w_sum_w = (ntst_pkg::SUMW'(r1_phi_w) << ntst_pkg::HALF) +
                     ntst_pkg::SUMW'(r1_plo_w);
    assign w_sum_l = (ntst_pkg::SUMW'(r1_phi_l) << ntst_pkg::HALF) +
                     ntst_pkg::SUMW'(r1_plo_l);

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r2_s   <= w_sum_w[ntst_pkg::SUMW-1:ntst_pkg::A1_FRAC];
            r2_l   <= w_sum_l[ntst_pkg::SUMW-1:ntst_pkg::A1_FRAC];
            r2_tw  <= r1_tw;
            r2_tpi <= r1_tpi;
            r2_tfl <= r1_tfl;
            r2_th  <= r1_th;
            r2_tl  <= r1_tl;
        end
    end

    // stage 3: numerators, square and u*S partial products
    logic                             r3_vld;
    ntst_pkg::t_side                  r3_side;
    logic [NMW-1:0]                   w_na [NL];
    logic [NMW-1:0]                   w_nb [NL];
    logic [2*SLO-1:0]                 r3_sq_ll;
    logic [SLO+SHI-1:0]               r3_sq_lh;
    logic [2*SHI-1:0]                 r3_sq_hh;
    logic [UMW+SLO-1:0]               r3_us_lo [NL];
    logic [UMW+SHI-1:0]               r3_us_hi [NL];

    always_comb begin
        w_na[ntst_pkg::LANE_TAJIMA] = NMW'(r2_tpi);
        w_nb[ntst_pkg::LANE_TAJIMA] = NMW'(r2_tw);
        w_na[ntst_pkg::LANE_FULI_D] = r2_s;
        w_nb[ntst_pkg::LANE_FULI_D] = r2_l;
        w_na[ntst_pkg::LANE_FULI_F] = NMW'(r2_tpi);
        w_nb[ntst_pkg::LANE_FULI_F] = NMW'(r2_tfl);
        w_na[ntst_pkg::LANE_FAYWU]  = NMW'(r2_tpi);
        w_nb[ntst_pkg::LANE_FAYWU]  = NMW'(r2_th);
        w_na[ntst_pkg::LANE_ZENG]   = NMW'(r2_tl);
        w_nb[ntst_pkg::LANE_ZENG]   = NMW'(r2_tw);
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            for (int k = 0; k < NL; k++) begin
                r3_side.nneg[k] <= w_nb[k] > w_na[k];
                r3_side.nmag[k] <= (w_nb[k] > w_na[k]) ? w_nb[k] - w_na[k]
                                                         : w_na[k] - w_nb[k];
                r3_us_lo[k] <= (UMW+SLO)'(r_umag[k]) * (UMW+SLO)'(r2_s[SLO-1:0]);
                r3_us_hi[k] <= (UMW+SHI)'(r_umag[k]) * (UMW+SHI)'(r2_s[SW-1:SLO]);
            end
            r3_side.bad   <= '0;
            r3_side.szero <= r2_s == '0;
            r3_sq_ll <= (2*SLO)'(r2_s[SLO-1:0]) * (2*SLO)'(r2_s[SLO-1:0]);
            r3_sq_lh <= (SLO+SHI)'(r2_s[SLO-1:0]) * (SLO+SHI)'(r2_s[SW-1:SLO]);
            r3_sq_hh <= (2*SHI)'(r2_s[SW-1:SLO]) * (2*SHI)'(r2_s[SW-1:SLO]);
        end
    end

    // stage 4: S*S and u*S sums
    logic                         r4_vld;
    ntst_pkg::t_side              r4_side;
    logic [ntst_pkg::SSW-1:0]     r4_ss;
    logic [ntst_pkg::USW-1:0]     r4_us [NL];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r4_side <= r3_side;
            r4_ss <= ntst_pkg::SSW'(r3_sq_ll) +
                     (ntst_pkg::SSW'(r3_sq_lh) << (SLO + 1)) +
                     (ntst_pkg::SSW'(r3_sq_hh) << (2 * SLO));
            for (int k = 0; k < NL; k++) begin
                r4_us[k] <= ntst_pkg::USW'(r3_us_lo[k]) +
                            (ntst_pkg::USW'(r3_us_hi[k]) << SLO);
            end
        end
    end

    // stage 5: v*S*S partial products
    logic                         r5_vld;
    ntst_pkg::t_side              r5_side;
    logic [ntst_pkg::VPW-1:0]     r5_vp [NL][ntst_pkg::SSCH];
    logic [ntst_pkg::USW-1:0]     r5_us [NL];

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r5_side <= r4_side;
            for (int k = 0; k < NL; k++) begin
                r5_us[k] <= r4_us[k];
                for (int c = 0; c < ntst_pkg::SSCH; c++) begin
                    r5_vp[k][c] <= ntst_pkg::VPW'(r_vmag[k]) *
                                   ntst_pkg::VPW'(r4_ss[c*ntst_pkg::SSCW +: ntst_pkg::SSCW]);
                end
            end
        end
    end

    // stage 6: both terms of the denominator
    logic                         r6_vld;
    ntst_pkg::t_side              r6_side;
    logic [ntst_pkg::PAW-1:0]     r6_pa [NL];
    logic [ntst_pkg::PBW-1:0]     r6_pb [NL];
    logic [ntst_pkg::PBW-1:0]     w_pb [NL];

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            w_pb[k] = '0;
            for (int c = 0; c < ntst_pkg::SSCH; c++) begin
                w_pb[k] = w_pb[k] + (ntst_pkg::PBW'(r5_vp[k][c]) << (c * ntst_pkg::SSCW));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r6_side <= r5_side;
            for (int k = 0; k < NL; k++) begin
                r6_pa[k] <= ntst_pkg::PAW'(r5_us[k]) << ntst_pkg::THETA_FRAC_BITS;
                r6_pb[k] <= w_pb[k];
            end
        end
    end

    // stage 7 and square root, one root bit per stage
    logic                   r_sq_vld  [RTW+1];
    ntst_pkg::t_side        r_sq_side [RTW+1];
    logic [DW-1:0]          r_sq_rad  [RTW+1][NL];
    logic [SREMW-1:0]       r_sq_rem  [RTW+1][NL];
    logic [RTW-1:0]         r_sq_root [RTW+1][NL];
    logic [DW-1:0]          w_d [NL];
    ntst_pkg::t_side        w_side0;

    always_comb begin
        w_side0 = r6_side;
        for (int k = 0; k < NL; k++) begin
            w_d[k] = (r_uneg[k] ? -DW'(r6_pa[k]) : DW'(r6_pa[k])) +
                     (r_vneg[k] ? -DW'(r6_pb[k]) : DW'(r6_pb[k]));
            w_side0.bad[k] = w_d[k][DW-1] || (w_d[k] == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_sq_side[0] <= w_side0;
            for (int k = 0; k < NL; k++) begin
                r_sq_rad[0][k]  <= w_d[k];
                r_sq_rem[0][k]  <= '0;
                r_sq_root[0][k] <= '0;
            end
        end
    end

    for (genvar g = 0; g < RTW; g++) begin : g_sqrt
        logic [SREMW-1:0] w_cand  [NL];
        logic [SREMW-1:0] w_trial [NL];
        logic [NL-1:0]    w_ge;

        always_comb begin
            for (int k = 0; k < NL; k++) begin
                w_cand[k]  = {r_sq_rem[g][k][SREMW-3:0], r_sq_rad[g][k][DW-1:DW-2]};
                w_trial[k] = SREMW'({r_sq_root[g][k], 2'b01});
                w_ge[k]    = w_cand[k] >= w_trial[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_sq_side[g+1] <= r_sq_side[g];
                for (int k = 0; k < NL; k++) begin
                    r_sq_rem[g+1][k]  <= w_ge[k] ? w_cand[k] - w_trial[k] : w_cand[k];
                    r_sq_root[g+1][k] <= {r_sq_root[g][k][RTW-2:0], w_ge[k]};
                    r_sq_rad[g+1][k]  <= r_sq_rad[g][k] << 2;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_vld[g+1] <= 1'b0;
            end else if (w_ce) begin
                r_sq_vld[g+1] <= r_sq_vld[g];
            end
        end
    end

    // saturation check and division, one quotient bit per stage
    logic                   r_dv_vld  [QW+1];
    ntst_pkg::t_side        r_dv_side [QW+1];
    logic [NL-1:0]          r_dv_sat  [QW+1];
    logic [RTW-1:0]         r_dv_root [QW+1][NL];
    logic [DREMW-1:0]       r_dv_rem  [QW+1][NL];
    logic [QW-1:0]          r_dv_nlo  [QW+1][NL];
    logic [QW-1:0]          r_dv_q    [QW+1][NL];
    logic [ntst_pkg::NHW-1:0] w_nhi [NL];

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            w_nhi[k] = r_sq_side[RTW].nmag[k][NMW-1:ntst_pkg::NLOW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r_dv_side[0] <= r_sq_side[RTW];
            for (int k = 0; k < NL; k++) begin
                r_dv_sat[0][k]  <= RTW'(w_nhi[k]) >= r_sq_root[RTW][k];
                r_dv_root[0][k] <= r_sq_root[RTW][k];
                r_dv_rem[0][k]  <= DREMW'(w_nhi[k]);
                r_dv_nlo[0][k]  <= QW'(r_sq_side[RTW].nmag[k][ntst_pkg::NLOW-1:0])
                                   << ntst_pkg::NSH;
                r_dv_q[0][k]    <= '0;
            end
        end
    end

    for (genvar g = 0; g < QW; g++) begin : g_div
        logic [DREMW-1:0] w_cand [NL];
        logic [NL-1:0]    w_ge;

        always_comb begin
            for (int k = 0; k < NL; k++) begin
                w_cand[k] = {r_dv_rem[g][k][DREMW-2:0], r_dv_nlo[g][k][QW-1]};
                w_ge[k]   = w_cand[k] >= DREMW'(r_dv_root[g][k]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_ce) begin
                r_dv_side[g+1] <= r_dv_side[g];
                r_dv_sat[g+1]  <= r_dv_sat[g];
                for (int k = 0; k < NL; k++) begin
                    r_dv_rem[g+1][k]  <= w_ge[k] ? w_cand[k] - DREMW'(r_dv_root[g][k])
                                                 : w_cand[k];
                    r_dv_q[g+1][k]    <= {r_dv_q[g][k][QW-2:0], w_ge[k]};
                    r_dv_nlo[g+1][k]  <= r_dv_nlo[g][k] << 1;
                    r_dv_root[g+1][k] <= r_dv_root[g][k];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_vld[g+1] <= 1'b0;
            end else if (w_ce) begin
                r_dv_vld[g+1] <= r_dv_vld[g];
            end
        end
    end

    // final stage: sign, saturation, invalid mask
    logic                          r_fin_vld;
    logic [ntst_pkg::OTW-1:0]      r_fin_data;
    logic [ntst_pkg::OTW-1:0]      w_pack;
    logic [QW-1:0]                 w_q   [NL];
    logic [OW-1:0]                 w_res [NL];
    logic [NL-1:0]                 w_mask;

    always_comb begin
        w_pack = '0;
        for (int k = 0; k < NL; k++) begin
            w_q[k] = r_dv_sat[QW][k] ? '1 : r_dv_q[QW][k];
            if (r_dv_side[QW].nneg[k]) begin
                w_res[k] = w_q[k][QW-1] ? {1'b1, {(OW-1){1'b0}}} : OW'(-w_q[k]);
            end else begin
                w_res[k] = w_q[k][QW-1] ? {1'b0, {(OW-1){1'b1}}} : OW'(w_q[k]);
            end
            w_mask[k] = r_dv_side[QW].bad[k];
            if (r_dv_side[QW].bad[k]) w_res[k] = '0;
        end
        if (r_dv_side[QW].szero) begin
            w_res[ntst_pkg::LANE_TAJIMA]  = '0;
            w_mask[ntst_pkg::LANE_TAJIMA] = 1'b0;
        end
        for (int k = 0; k < NL; k++) w_pack[k*OW +: OW] = w_res[k];
        w_pack[NL*OW +: NL] = w_mask;
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) r_fin_data <= w_pack;
    end

    // valid bits of the front stages, the root and division entries and the final stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld      <= 1'b0;
            r2_vld      <= 1'b0;
            r3_vld      <= 1'b0;
            r4_vld      <= 1'b0;
            r5_vld      <= 1'b0;
            r6_vld      <= 1'b0;
            r_sq_vld[0] <= 1'b0;
            r_dv_vld[0] <= 1'b0;
            r_fin_vld   <= 1'b0;
        end else if (w_ce) begin
            r1_vld      <= s_axis_tvalid;
            r2_vld      <= r1_vld;
            r3_vld      <= r2_vld;
            r4_vld      <= r3_vld;
            r5_vld      <= r4_vld;
            r6_vld      <= r5_vld;
            r_sq_vld[0] <= r6_vld;
            r_dv_vld[0] <= r_sq_vld[RTW];
            r_fin_vld   <= r_dv_vld[QW];
        end
    end

    // output register and skid
    logic                      r_out_vld, r_skid_vld;
    logic [ntst_pkg::OTW-1:0]  r_out_data, r_skid_data;

    assign w_ce          = !r_skid_vld;
    assign s_axis_tready = !r_skid_vld;
    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (w_ce) begin
            if (r_fin_vld) begin
                if (!r_out_vld || m_axis_tready) begin
                    r_out_data <= r_fin_data;
                    r_out_vld  <= 1'b1;
                end else begin
                    r_skid_data <= r_fin_data;
                    r_skid_vld  <= 1'b1;
                end
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end else if (m_axis_tready) begin
            r_out_data <= r_skid_data;
            r_skid_vld <= 1'b0;
        end
    end

endmodule

@@ sv/ntst_checker.sv @@
module ntst_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         s_axis_tready,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [ntst_pkg::OTW-1:0]     m_axis_tdata
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output item changed while stalled");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid && !$past(m_axis_tready))
        else $error("input stalled without a blocked output");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (!m_axis_tdata[160] || m_axis_tdata[31:0] == 32'd0) &&
            (!m_axis_tdata[161] || m_axis_tdata[63:32] == 32'd0) &&
            (!m_axis_tdata[162] || m_axis_tdata[95:64] == 32'd0) &&
            (!m_axis_tdata[163] || m_axis_tdata[127:96] == 32'd0) &&
            (!m_axis_tdata[164] || m_axis_tdata[159:128] == 32'd0))
        else $error("flagged statistic is not zero");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[167:165] == 3'd0)
        else $error("pad bits set");

endmodule

bind neutrality_test_statistics_unit ntst_checker u_ntst_checker (.*);
